/* hw/rtl/sppe_pkg.sv */
// Shared constants, types and command/status structs for the point error block.
package sppe_pkg;

  localparam int MaxPoints = 1024;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int CoordW    = 16;
  localparam int PointW    = 3 * CoordW;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * DiffW;
  localparam int DistW     = 36;
  localparam int SumW      = DistW + IdxW;
  localparam int MeanW     = 37;

  localparam logic [1:0] KindLoadA   = 2'd0;
  localparam logic [1:0] KindLoadB   = 2'd1;
  localparam logic [1:0] KindCompute = 2'd2;
  localparam logic [1:0] KindClear   = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusEmpty    = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            wr_a;
    logic            wr_b;
    logic [IdxW-1:0] wr_idx;
    logic            dir_ba;
    logic [IdxW-1:0] src_idx;
    logic [IdxW-1:0] dst_idx;
    logic            rd;
    logic            first_dst;
    logic            last_dst;
    logic            clr_sum;
    logic            clr_max;
    logic            div_start;
    logic [CntW-1:0] div_den;
    logic            mean_clr;
  } sppe_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic div_busy;
  } sppe_sts_t;

endpackage

/* hw/rtl/symmetric_point_to_point_error_core.sv */
// Top level of the symmetric point-to-point error block.
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, kind_i, coord_*_i | sink
//  out     | out_valid_o, out_stall_i, result fields   | source
//
// Load and clear transfers complete without leaving the idle state. A compute
// transfer offers its result after a scan of one point pair per cycle through a
// single distance pipeline, then a pipeline drain and a bit-serial divide per
// direction. With an empty set the controller goes straight from idle to the
// result state.
// Reset clears the counts and the overflow flag; point memories are not cleared.
// The input stalls while a compute is in flight or its result waits.
module symmetric_point_to_point_error_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [sppe_pkg::CoordW-1:0]  coord_x_i,
  input  logic signed [sppe_pkg::CoordW-1:0]  coord_y_i,
  input  logic signed [sppe_pkg::CoordW-1:0]  coord_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sppe_pkg::DistW-1:0]          max_sqr_distance_o,
  output logic [sppe_pkg::MeanW-1:0]          mean_sqr_distance_x2_o,
  output logic [1:0]                          status_o
);

  sppe_pkg::sppe_cmd_t          cmd;
  sppe_pkg::sppe_sts_t          sts;
  logic                         empty;
  logic [sppe_pkg::DistW-1:0]   max_v;
  logic [sppe_pkg::MeanW-1:0]   mean_v;

  sppe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .empty_o     (empty),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sppe_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_point_i ({coord_z_i, coord_y_i, coord_x_i}),
    .sts_o      (sts),
    .max_o      (max_v),
    .mean_o     (mean_v)
  );

  // An empty set reports zero metrics.
  assign max_sqr_distance_o     = empty ? '0 : max_v;
  assign mean_sqr_distance_x2_o = empty ? '0 : mean_v;

endmodule

/* hw/rtl/sppe_div.sv */
// Restoring divider, one quotient bit per cycle.
module sppe_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sppe_pkg::SumW-1:0]      num_i,
  input  logic [sppe_pkg::CntW-1:0]      den_i,
  output logic                           busy_o,
  output logic [sppe_pkg::SumW-1:0]      quo_o
);

  localparam int StepW = $clog2(sppe_pkg::SumW + 1);

  logic [StepW-1:0]           step_q, step_d;
  logic [sppe_pkg::SumW-1:0]  quo_q, quo_d;
  logic [sppe_pkg::CntW-1:0]  rem_q, rem_d;
  logic [sppe_pkg::CntW-1:0]  den_q, den_d;
  logic [sppe_pkg::CntW:0]    trial;

  // Shift in the next numerator bit and try to subtract the divisor.
  always_comb begin
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[sppe_pkg::SumW-1]};
    if (start_i) begin
      step_d = StepW'(sppe_pkg::SumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = sppe_pkg::CntW'(trial - {1'b0, den_q});
        quo_d = {quo_q[sppe_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[sppe_pkg::CntW-1:0];
        quo_d = {quo_q[sppe_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (step_q != '0);
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/sppe_datapath.sv */
// Point memories, distance pipeline, min/max/sum accumulators and divider.
module sppe_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sppe_pkg::sppe_cmd_t            cmd_i,
  input  logic [sppe_pkg::PointW-1:0]    wr_point_i,
  output sppe_pkg::sppe_sts_t            sts_o,
  output logic [sppe_pkg::DistW-1:0]     max_o,
  output logic [sppe_pkg::MeanW-1:0]     mean_o
);

  localparam int W = sppe_pkg::CoordW;

  logic [sppe_pkg::PointW-1:0] mem_a [sppe_pkg::MaxPoints];
  logic [sppe_pkg::PointW-1:0] mem_b [sppe_pkg::MaxPoints];
  logic [sppe_pkg::PointW-1:0] a_src_q, a_dst_q, b_src_q, b_dst_q;
  logic                        rd_q, first_q, last_q, dir_q;
  logic                        sq_vld_q, sq_first_q, sq_last_q;
  logic [sppe_pkg::SqW-1:0]    sq_q [3];
  logic [sppe_pkg::PointW-1:0] src_p, dst_p;
  logic signed [sppe_pkg::DiffW-1:0] diff [3];
  logic [sppe_pkg::DistW-1:0]  pair_sq;
  logic [sppe_pkg::DistW-1:0]  best_q, best_d;
  logic [sppe_pkg::DistW-1:0]  max_q;
  logic [sppe_pkg::SumW-1:0]   sum_q;
  logic [sppe_pkg::MeanW-1:0]  mean_q;
  logic                        div_busy, div_busy_q;
  logic [sppe_pkg::SumW-1:0]   quo;

  // Memory ports: one write and two registered reads per set.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) mem_a[cmd_i.wr_idx] <= wr_point_i;
    if (cmd_i.wr_b) mem_b[cmd_i.wr_idx] <= wr_point_i;
    a_src_q <= mem_a[cmd_i.src_idx];
    a_dst_q <= mem_a[cmd_i.dst_idx];
    b_src_q <= mem_b[cmd_i.src_idx];
    b_dst_q <= mem_b[cmd_i.dst_idx];
  end

  // Pick the source and target set for the current direction.
  assign src_p = dir_q ? b_src_q : a_src_q;
  assign dst_p = dir_q ? a_dst_q : b_dst_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({src_p[k*W+W-1], src_p[k*W +: W]})
              - $signed({dst_p[k*W+W-1], dst_p[k*W +: W]});
    end
  end

  // Stage 1 registers the read tags; stage 2 squares each axis difference.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= 1'b0;
      sq_vld_q <= 1'b0;
    end else begin
      rd_q     <= cmd_i.rd;
      sq_vld_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= cmd_i.first_dst;
    last_q     <= cmd_i.last_dst;
    dir_q      <= cmd_i.dir_ba;
    sq_first_q <= first_q;
    sq_last_q  <= last_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sppe_pkg::SqW'(diff[k] * diff[k]);
    end
  end

  assign pair_sq = sppe_pkg::DistW'(sq_q[0]) + sppe_pkg::DistW'(sq_q[1])
                 + sppe_pkg::DistW'(sq_q[2]);

  // Running minimum over the targets of one source point.
  always_comb begin
    best_d = best_q;
    if (sq_first_q || pair_sq < best_q) best_d = pair_sq;
  end

  always_ff @(posedge clk_i) begin
    if (sq_vld_q) best_q <= best_d;
    if (cmd_i.clr_max) begin
      max_q <= '0;
    end else if (sq_vld_q && sq_last_q && best_d > max_q) begin
      max_q <= best_d;
    end
    if (cmd_i.clr_sum) begin
      sum_q <= '0;
    end else if (sq_vld_q && sq_last_q) begin
      sum_q <= sum_q + sppe_pkg::SumW'(best_d);
    end
    div_busy_q <= div_busy;
    if (cmd_i.mean_clr) begin
      mean_q <= '0;
    end else if (div_busy_q && !div_busy) begin
      mean_q <= mean_q + sppe_pkg::MeanW'(quo);
    end
  end

  sppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_q),
    .den_i   (cmd_i.div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign sts_o.div_busy = div_busy | div_busy_q;
  assign max_o  = max_q;
  assign mean_o = mean_q;

endmodule

/* hw/rtl/sppe_ctrl.sv */
// Controller: counts, load handling and the nested search sequence.
module sppe_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic                           empty_o,
  output sppe_pkg::sppe_cmd_t            cmd_o,
  input  sppe_pkg::sppe_sts_t            sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StWait  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam int         DrainN  = 3;

  logic [2:0]                 state_q, state_d;
  logic [sppe_pkg::CntW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                       ovf_q, ovf_d;
  logic                       dir_q, dir_d;
  logic [sppe_pkg::IdxW-1:0]  i_q, i_d, j_q, j_d;
  logic [1:0]                 drn_q, drn_d;
  logic [1:0]                 status_q, status_d;
  logic                       empty_q, empty_d;
  logic                       acc;
  logic [sppe_pkg::CntW-1:0]  ns, nd;
  logic                       last_j, last_i;

  assign acc    = in_valid_i && !in_stall_o;
  assign ns     = dir_q ? cnt_b_q : cnt_a_q;
  assign nd     = dir_q ? cnt_a_q : cnt_b_q;
  assign last_j = ({1'b0, j_q} == nd - 1'b1);
  assign last_i = ({1'b0, i_q} == ns - 1'b1);

  always_comb begin
    state_d  = state_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    ovf_d    = ovf_q;
    dir_d    = dir_q;
    i_d      = i_q;
    j_d      = j_q;
    drn_d    = drn_q;
    status_d = status_q;
    empty_d  = empty_q;
    cmd_o    = '0;
    cmd_o.dir_ba  = dir_q;
    cmd_o.src_idx = i_q;
    cmd_o.dst_idx = j_q;
    cmd_o.div_den = ns;
    cmd_o.wr_idx  = (kind_i == sppe_pkg::KindLoadA) ? cnt_a_q[sppe_pkg::IdxW-1:0]
                                                    : cnt_b_q[sppe_pkg::IdxW-1:0];
    case (state_q)
      StIdle: begin
        if (acc) begin
          case (kind_i)
            sppe_pkg::KindLoadA: begin
              if (cnt_a_q == sppe_pkg::CntW'(sppe_pkg::MaxPoints)) ovf_d = 1'b1;
              else begin
                cmd_o.wr_a = 1'b1;
                cnt_a_d    = cnt_a_q + 1'b1;
              end
            end
            sppe_pkg::KindLoadB: begin
              if (cnt_b_q == sppe_pkg::CntW'(sppe_pkg::MaxPoints)) ovf_d = 1'b1;
              else begin
                cmd_o.wr_b = 1'b1;
                cnt_b_d    = cnt_b_q + 1'b1;
              end
            end
            sppe_pkg::KindClear: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
              ovf_d   = 1'b0;
            end
            default: begin
              cmd_o.clr_max  = 1'b1;
              cmd_o.clr_sum  = 1'b1;
              cmd_o.mean_clr = 1'b1;
              dir_d = 1'b0;
              i_d   = '0;
              j_d   = '0;
              if (cnt_a_q == '0 || cnt_b_q == '0) begin
                status_d = sppe_pkg::StatusEmpty;
                empty_d  = 1'b1;
                state_d  = StOut;
              end else begin
                status_d = ovf_q ? sppe_pkg::StatusOverflow : sppe_pkg::StatusOk;
                empty_d  = 1'b0;
                state_d  = StScan;
              end
            end
          endcase
        end
      end
      // Issue one pair read per cycle: inner loop over targets.
      StScan: begin
        cmd_o.rd        = 1'b1;
        cmd_o.first_dst = (j_q == '0);
        cmd_o.last_dst  = last_j;
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            drn_d   = 2'(DrainN);
            state_d = StDrain;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      // Let the pipeline finish the last sum before dividing.
      StDrain: begin
        if (drn_q == '0) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          drn_d = drn_q - 1'b1;
        end
      end
      StDiv: state_d = StWait;
      StWait: begin
        if (!sts_i.div_busy) begin
          if (!dir_q) begin
            dir_d         = 1'b1;
            i_d           = '0;
            cmd_o.clr_sum = 1'b1;
            state_d       = StScan;
          end else begin
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q    <= dir_d;
    i_q      <= i_d;
    j_q      <= j_d;
    drn_q    <= drn_d;
    status_q <= status_d;
    empty_q  <= empty_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign status_o    = status_q;
  assign empty_o     = empty_q;

endmodule
